/* rtl/core/rtti_pkg.sv */
// Shared types and constants for the trap and interrupt unit.
`timescale 1ns / 1ps

package rtti_pkg;

    // Privilege levels.
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // Bit positions inside mstatus.
    localparam int ST_SIE    = 1;
    localparam int ST_MIE    = 3;
    localparam int ST_SPIE   = 5;
    localparam int ST_MPIE   = 7;
    localparam int ST_SPP    = 8;
    localparam int ST_MPP_LO = 11;
    localparam int ST_MPP_HI = 12;

    // Interrupt numbers in the mip/mie layout.
    localparam logic [3:0] IRQ_SSI = 4'd1;
    localparam logic [3:0] IRQ_MSI = 4'd3;
    localparam logic [3:0] IRQ_STI = 4'd5;
    localparam logic [3:0] IRQ_MTI = 4'd7;
    localparam logic [3:0] IRQ_SEI = 4'd9;
    localparam logic [3:0] IRQ_MEI = 4'd11;

    // Trap vector mode field.
    localparam logic [1:0] TVEC_VECTORED = 2'd1;

    // Configuration register indexes.
    localparam int         CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MTVEC  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STVEC  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDELEG = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDELEG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IE     = 3'd4;

    // Configuration register contents.
    typedef struct packed {
        logic [31:0] mtvec;
        logic [31:0] stvec;
        logic [15:0] edeleg;
        logic [11:0] ideleg;
        logic [11:0] ie;
    } cfg_t;

    // One incoming request as it arrives on the ports.
    typedef struct packed {
        logic [31:0] cur_pc;
        logic [31:0] following_pc;
        logic [1:0]  cur_priv;
        logic [31:0] status_in;
        logic        exc_valid;
        logic [3:0]  exc_code;
        logic [31:0] fault_value;
        logic [11:0] pending_lines;
        logic        ext_super_external;
        logic        ext_super_timer;
    } req_t;

    // After masking: candidates in priority order, index 0 highest.
    typedef struct packed {
        logic [31:0] cur_pc;
        logic [31:0] following_pc;
        logic [1:0]  cur_priv;
        logic [31:0] status_in;
        logic        exc_valid;
        logic [3:0]  exc_code;
        logic        exc_to_s;
        logic [31:0] fault_value;
        logic [5:0]  m_pri;
        logic [2:0]  s_pri;
    } mask_t;

    // After selection: the trap decision.
    typedef struct packed {
        logic        taken;
        logic        to_s;
        logic        intr;
        logic [3:0]  code;
        logic [31:0] saved_pc;
        logic [31:0] trap_value;
        logic [31:0] following_pc;
        logic [1:0]  cur_priv;
        logic [31:0] status_in;
    } sel_t;

    // Final result.
    typedef struct packed {
        logic        trap_taken;
        logic        to_supervisor;
        logic        interrupt_trap;
        logic [3:0]  cause_code;
        logic [31:0] saved_pc;
        logic [31:0] trap_value;
        logic [31:0] next_pc;
        logic [1:0]  next_priv;
        logic [31:0] status_out;
    } rsp_t;

endpackage

/* rtl/core/rtti_cfg_regs.sv */
// Configuration registers of the trap and interrupt unit.
`timescale 1ns / 1ps

module rtti_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output rtti_pkg::cfg_t                 cfg
);

    rtti_pkg::cfg_t cfg_reg;
    rtti_pkg::cfg_t cfg_next;

    // Writes are always taken.
    assign cfg_ready = 1'b1;

    // Decode the register index; unknown indexes leave everything unchanged.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                rtti_pkg::CFG_MTVEC:  cfg_next.mtvec  = cfg_data;
                rtti_pkg::CFG_STVEC:  cfg_next.stvec  = cfg_data;
                rtti_pkg::CFG_EDELEG: cfg_next.edeleg = cfg_data[15:0];
                rtti_pkg::CFG_IDELEG: cfg_next.ideleg = cfg_data[11:0];
                rtti_pkg::CFG_IE:     cfg_next.ie     = cfg_data[11:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/rtti_irq_mask.sv */
// First stage: merges interrupt lines, applies enables, delegation and eligibility.
`timescale 1ns / 1ps

module rtti_irq_mask (
    input  logic            aclk,
    input  logic            aresetn,
    input  rtti_pkg::cfg_t  cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  rtti_pkg::req_t  in_req,
    output logic            out_valid,
    input  logic            out_ready,
    output rtti_pkg::mask_t out_item
);

    logic            valid_reg;
    rtti_pkg::mask_t item_reg;
    rtti_pkg::mask_t item_next;

    logic [11:0] mip;
    logic [11:0] m_act;
    logic [11:0] s_act;
    logic        m_ok;
    logic        s_ok;

    // Pending lines with the external supervisor lines folded in.
    always_comb begin
        mip = in_req.pending_lines;
        mip[rtti_pkg::IRQ_SEI] = mip[rtti_pkg::IRQ_SEI] | in_req.ext_super_external;
        mip[rtti_pkg::IRQ_STI] = mip[rtti_pkg::IRQ_STI] | in_req.ext_super_timer;
        m_act = mip & cfg.ie & ~cfg.ideleg;
        s_act = mip & cfg.ie;
    end

    // Global enables depend on the current privilege; reserved privilege
    // two counts as below M but not as S.
    assign m_ok = ((in_req.cur_priv == rtti_pkg::PRIV_M) && in_req.status_in[rtti_pkg::ST_MIE])
                  || (in_req.cur_priv != rtti_pkg::PRIV_M);
    assign s_ok = ((in_req.cur_priv == rtti_pkg::PRIV_S) && in_req.status_in[rtti_pkg::ST_SIE])
                  || (in_req.cur_priv == rtti_pkg::PRIV_U);

    // Build the stage payload with candidates in priority order.
    always_comb begin
        item_next.cur_pc       = in_req.cur_pc;
        item_next.following_pc = in_req.following_pc;
        item_next.cur_priv     = in_req.cur_priv;
        item_next.status_in    = in_req.status_in;
        item_next.exc_valid    = in_req.exc_valid;
        item_next.exc_code     = in_req.exc_code;
        item_next.exc_to_s     = cfg.edeleg[in_req.exc_code]
                                 && (in_req.cur_priv != rtti_pkg::PRIV_M);
        item_next.fault_value  = in_req.fault_value;
        item_next.m_pri = {m_act[rtti_pkg::IRQ_STI], m_act[rtti_pkg::IRQ_SSI],
                           m_act[rtti_pkg::IRQ_SEI], m_act[rtti_pkg::IRQ_MTI],
                           m_act[rtti_pkg::IRQ_MSI], m_act[rtti_pkg::IRQ_MEI]} & {6{m_ok}};
        item_next.s_pri = {s_act[rtti_pkg::IRQ_STI], s_act[rtti_pkg::IRQ_SSI],
                           s_act[rtti_pkg::IRQ_SEI]} & {3{s_ok}};
    end

    // Stage register; it loads whenever it is empty or its result moves on.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/core/rtti_select.sv */
// Second stage: picks the exception or the highest-priority interrupt.
`timescale 1ns / 1ps

module rtti_select (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rtti_pkg::mask_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output rtti_pkg::sel_t  out_item
);

    logic           valid_reg;
    rtti_pkg::sel_t item_reg;
    rtti_pkg::sel_t item_next;

    // Exceptions win; then M-level candidates, then S-level ones.
    always_comb begin
        item_next.taken = 1'b1;
        item_next.to_s  = 1'b0;
        item_next.intr  = 1'b1;
        item_next.code  = '0;
        if (in_item.exc_valid) begin
            item_next.intr = 1'b0;
            item_next.code = in_item.exc_code;
            item_next.to_s = in_item.exc_to_s;
        end else if (in_item.m_pri[0]) begin
            item_next.code = rtti_pkg::IRQ_MEI;
        end else if (in_item.m_pri[1]) begin
            item_next.code = rtti_pkg::IRQ_MSI;
        end else if (in_item.m_pri[2]) begin
            item_next.code = rtti_pkg::IRQ_MTI;
        end else if (in_item.m_pri[3]) begin
            item_next.code = rtti_pkg::IRQ_SEI;
        end else if (in_item.m_pri[4]) begin
            item_next.code = rtti_pkg::IRQ_SSI;
        end else if (in_item.m_pri[5]) begin
            item_next.code = rtti_pkg::IRQ_STI;
        end else if (in_item.s_pri[0]) begin
            item_next.to_s = 1'b1;
            item_next.code = rtti_pkg::IRQ_SEI;
        end else if (in_item.s_pri[1]) begin
            item_next.to_s = 1'b1;
            item_next.code = rtti_pkg::IRQ_SSI;
        end else if (in_item.s_pri[2]) begin
            item_next.to_s = 1'b1;
            item_next.code = rtti_pkg::IRQ_STI;
        end else begin
            item_next.taken = 1'b0;
            item_next.intr  = 1'b0;
        end

        // Interrupts resume after the instruction, exceptions redo it.
        if (!item_next.taken) begin
            item_next.saved_pc   = '0;
            item_next.trap_value = '0;
        end else begin
            item_next.saved_pc   = item_next.intr ? in_item.following_pc : in_item.cur_pc;
            item_next.trap_value = in_item.fault_value;
        end
        item_next.following_pc = in_item.following_pc;
        item_next.cur_priv     = in_item.cur_priv;
        item_next.status_in    = in_item.status_in;
    end

    // Stage register.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

/* rtl/core/rtti_commit.sv */
// Third stage: handler address, new privilege and new mstatus; holds the result.
`timescale 1ns / 1ps

module rtti_commit (
    input  logic           aclk,
    input  logic           aresetn,
    input  rtti_pkg::cfg_t cfg,
    input  logic           in_valid,
    output logic           in_ready,
    input  rtti_pkg::sel_t in_item,
    output logic           out_valid,
    input  logic           out_ready,
    output rtti_pkg::rsp_t out_item
);

    logic           valid_reg;
    rtti_pkg::rsp_t item_reg;
    rtti_pkg::rsp_t item_next;

    logic [31:0] tvec;
    logic [31:0] offset;
    logic [31:0] target;
    logic [31:0] status_trap;

    // Handler address: base, plus four times the cause for vectored interrupts.
    // Reserved modes behave as direct.
    always_comb begin
        tvec   = in_item.to_s ? cfg.stvec : cfg.mtvec;
        offset = '0;
        if ((tvec[1:0] == rtti_pkg::TVEC_VECTORED) && in_item.intr) begin
            offset = {26'd0, in_item.code, 2'b00};
        end
        target = {tvec[31:2], 2'b00} + offset;
    end

    // Stack the interrupt enable and record the previous privilege.
    always_comb begin
        status_trap = in_item.status_in;
        if (in_item.to_s) begin
            status_trap[rtti_pkg::ST_SPIE] = in_item.status_in[rtti_pkg::ST_SIE];
            status_trap[rtti_pkg::ST_SIE]  = 1'b0;
            status_trap[rtti_pkg::ST_SPP]  = in_item.cur_priv[0];
        end else begin
            status_trap[rtti_pkg::ST_MPIE] = in_item.status_in[rtti_pkg::ST_MIE];
            status_trap[rtti_pkg::ST_MIE]  = 1'b0;
            status_trap[rtti_pkg::ST_MPP_HI:rtti_pkg::ST_MPP_LO] = in_item.cur_priv;
        end
    end

    // Assemble the result; without a trap the hart state passes unchanged.
    always_comb begin
        item_next.trap_taken     = in_item.taken;
        item_next.to_supervisor  = in_item.to_s;
        item_next.interrupt_trap = in_item.intr;
        item_next.cause_code     = in_item.code;
        item_next.saved_pc       = in_item.saved_pc;
        item_next.trap_value     = in_item.trap_value;
        if (in_item.taken) begin
            item_next.next_pc    = target;
            item_next.next_priv  = in_item.to_s ? rtti_pkg::PRIV_S : rtti_pkg::PRIV_M;
            item_next.status_out = status_trap;
        end else begin
            item_next.next_pc    = in_item.following_pc;
            item_next.next_priv  = in_item.cur_priv;
            item_next.status_out = in_item.status_in;
        end
    end

    // Output register.
    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

`ifndef NO_ASSERTIONS
    // A supervisor trap always lands in S mode.
    a_s_trap_priv: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && item_reg.trap_taken && item_reg.to_supervisor)
        |-> (item_reg.next_priv == rtti_pkg::PRIV_S))
        else $error("supervisor trap did not enter S mode");

    // A machine trap lands in M mode with MIE cleared.
    a_m_trap_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && item_reg.trap_taken && !item_reg.to_supervisor)
        |-> ((item_reg.next_priv == rtti_pkg::PRIV_M)
             && !item_reg.status_out[rtti_pkg::ST_MIE]))
        else $error("machine trap left MIE set or privilege wrong");

    // Without a trap, the supervisor, interrupt, cause and saved pc fields are zero.
    a_no_trap_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !item_reg.trap_taken)
        |-> (!item_reg.to_supervisor && !item_reg.interrupt_trap
             && (item_reg.cause_code == 4'd0) && (item_reg.saved_pc == 32'd0)))
        else $error("trap record not cleared when no trap was taken");
`endif

endmodule

/* rtl/core/riscv_trap_and_interrupt_unit.sv */
// Top level of the trap and interrupt unit.
`timescale 1ns / 1ps

// Trap and interrupt unit for a hart with M, S and U modes.
// Requests arrive on the s_ channel, one per retired instruction: pc, next pc,
// privilege, mstatus, pending interrupt lines and an optional exception. Each
// request yields exactly one result on the m_ channel: whether a trap is
// taken, its cause, xepc, xtval, the next pc, privilege and mstatus.
// The cfg_ channel writes the trap vectors, delegation masks and interrupt
// enables; write it only while no request is in flight.
// The request passes three register stages: one for interrupt masking, one for
// priority selection, one for the handler address add and mstatus update.
// m_valid rises once the request has passed the mask, select and commit
// registers. A new request is taken in every cycle while s_ready is high.
// When the receiver stalls, the result holds on the m_ ports and the stages
// behind it keep filling; s_ready drops once all three stages are occupied.
// Reset clears all configuration registers to zero and empties the pipeline.
module riscv_trap_and_interrupt_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtti_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [31:0]                    s_cur_pc,
    input  logic [31:0]                    s_following_pc,
    input  logic [1:0]                     s_cur_priv,
    input  logic [31:0]                    s_status_in,
    input  logic                           s_exc_valid,
    input  logic [3:0]                     s_exc_code,
    input  logic [31:0]                    s_fault_value,
    input  logic [11:0]                    s_pending_lines,
    input  logic                           s_ext_super_external,
    input  logic                           s_ext_super_timer,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_trap_taken,
    output logic                           m_to_supervisor,
    output logic                           m_interrupt_trap,
    output logic [3:0]                     m_cause_code,
    output logic [31:0]                    m_saved_pc,
    output logic [31:0]                    m_trap_value,
    output logic [31:0]                    m_next_pc,
    output logic [1:0]                     m_next_priv,
    output logic [31:0]                    m_status_out
);

    rtti_pkg::cfg_t  cfg;
    rtti_pkg::req_t  req;
    rtti_pkg::mask_t mask_item;
    rtti_pkg::sel_t  sel_item;
    rtti_pkg::rsp_t  rsp;
    logic            mask_valid;
    logic            mask_ready;
    logic            sel_valid;
    logic            sel_ready;

    // Configuration registers.
    rtti_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Gather the request fields.
    always_comb begin
        req.cur_pc             = s_cur_pc;
        req.following_pc       = s_following_pc;
        req.cur_priv           = s_cur_priv;
        req.status_in          = s_status_in;
        req.exc_valid          = s_exc_valid;
        req.exc_code           = s_exc_code;
        req.fault_value        = s_fault_value;
        req.pending_lines      = s_pending_lines;
        req.ext_super_external = s_ext_super_external;
        req.ext_super_timer    = s_ext_super_timer;
    end

    // Stage one: masking and eligibility.
    rtti_irq_mask u_mask (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_req    (req),
        .out_valid (mask_valid),
        .out_ready (mask_ready),
        .out_item  (mask_item)
    );

    // Stage two: priority selection.
    rtti_select u_select (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mask_valid),
        .in_ready  (mask_ready),
        .in_item   (mask_item),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .out_item  (sel_item)
    );

    // Stage three: handler address and state update.
    rtti_commit u_commit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .in_item   (sel_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_item  (rsp)
    );

    // Result fields.
    assign m_trap_taken     = rsp.trap_taken;
    assign m_to_supervisor  = rsp.to_supervisor;
    assign m_interrupt_trap = rsp.interrupt_trap;
    assign m_cause_code     = rsp.cause_code;
    assign m_saved_pc       = rsp.saved_pc;
    assign m_trap_value     = rsp.trap_value;
    assign m_next_pc        = rsp.next_pc;
    assign m_next_priv      = rsp.next_priv;
    assign m_status_out     = rsp.status_out;

`ifndef NO_ASSERTIONS
    // Requests are refused only when every stage is full and the output stalls.
    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && mask_valid && sel_valid))
        else $error("input blocked while the pipeline had room");
`endif

endmodule

/* bench/tb_riscv_trap_and_interrupt_unit.sv */
// Self-checking testbench for the trap and interrupt unit: directed and random requests.
`timescale 1ns / 1ps

module tb_riscv_trap_and_interrupt_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 6;
    localparam int ITEMS_PER_SETTING = 86;

    // Interrupt numbers from highest to lowest priority; the last three are the S ones.
    localparam logic [3:0] IRQ_ORDER [0:5] = '{rtti_pkg::IRQ_MEI, rtti_pkg::IRQ_MSI,
                                               rtti_pkg::IRQ_MTI, rtti_pkg::IRQ_SEI,
                                               rtti_pkg::IRQ_SSI, rtti_pkg::IRQ_STI};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [rtti_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    logic s_valid = 1'b0;
    logic s_ready;
    rtti_pkg::req_t req_drive = '0;

    logic m_valid;
    logic m_ready = 1'b0;
    logic m_trap_taken;
    logic m_to_supervisor;
    logic m_interrupt_trap;
    logic [3:0] m_cause_code;
    logic [31:0] m_saved_pc;
    logic [31:0] m_trap_value;
    logic [31:0] m_next_pc;
    logic [1:0] m_next_priv;
    logic [31:0] m_status_out;

    // Copy of the configuration registers as last written.
    rtti_pkg::cfg_t shadow_cfg = '0;
    // Predicted trap decisions, oldest first.
    rtti_pkg::rsp_t trap_queue[$];

    int send_idle_pct = 10;
    int recv_idle_pct = 60;
    int fault_count = 0;
    int cycle_count = 0;

    riscv_trap_and_interrupt_unit i_dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_valid            (cfg_valid),
        .cfg_ready            (cfg_ready),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cur_pc             (req_drive.cur_pc),
        .s_following_pc       (req_drive.following_pc),
        .s_cur_priv           (req_drive.cur_priv),
        .s_status_in          (req_drive.status_in),
        .s_exc_valid          (req_drive.exc_valid),
        .s_exc_code           (req_drive.exc_code),
        .s_fault_value        (req_drive.fault_value),
        .s_pending_lines      (req_drive.pending_lines),
        .s_ext_super_external (req_drive.ext_super_external),
        .s_ext_super_timer    (req_drive.ext_super_timer),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_trap_taken         (m_trap_taken),
        .m_to_supervisor      (m_to_supervisor),
        .m_interrupt_trap     (m_interrupt_trap),
        .m_cause_code         (m_cause_code),
        .m_saved_pc           (m_saved_pc),
        .m_trap_value         (m_trap_value),
        .m_next_pc            (m_next_pc),
        .m_next_priv          (m_next_priv),
        .m_status_out         (m_status_out)
    );

    always #4 aclk = ~aclk;

    // Work out the trap decision for one request under the given registers.
    function automatic rtti_pkg::rsp_t predict_trap(rtti_pkg::req_t r, rtti_pkg::cfg_t c);
        rtti_pkg::rsp_t rsp;
        logic [11:0] lines;
        logic [11:0] m_cand;
        logic [11:0] s_cand;
        logic m_ok;
        logic s_ok;
        logic hit;
        logic [31:0] st;
        logic [31:0] tvec;
        int i;
        rsp = '0;
        hit = 1'b0;
        st = r.status_in;
        lines = r.pending_lines;
        lines[rtti_pkg::IRQ_SEI] = lines[rtti_pkg::IRQ_SEI] | r.ext_super_external;
        lines[rtti_pkg::IRQ_STI] = lines[rtti_pkg::IRQ_STI] | r.ext_super_timer;

        if (r.exc_valid) begin
            // Exceptions win; delegation only applies below M mode.
            hit = 1'b1;
            rsp.cause_code = r.exc_code;
            rsp.to_supervisor = c.edeleg[r.exc_code] && (r.cur_priv != rtti_pkg::PRIV_M);
        end else begin
            // The reserved privilege counts as below M but not as S.
            m_ok = (r.cur_priv == rtti_pkg::PRIV_M) ? st[rtti_pkg::ST_MIE] : 1'b1;
            s_ok = (r.cur_priv == rtti_pkg::PRIV_S) ? st[rtti_pkg::ST_SIE]
                                                     : (r.cur_priv == rtti_pkg::PRIV_U);
            m_cand = lines & c.ie & ~c.ideleg;
            s_cand = lines & c.ie;
            for (i = 0; i < 6; i++) begin
                if (!hit && m_ok && m_cand[IRQ_ORDER[i]]) begin
                    hit = 1'b1;
                    rsp.cause_code = IRQ_ORDER[i];
                end
            end
            for (i = 3; i < 6; i++) begin
                if (!hit && s_ok && s_cand[IRQ_ORDER[i]]) begin
                    hit = 1'b1;
                    rsp.to_supervisor = 1'b1;
                    rsp.cause_code = IRQ_ORDER[i];
                end
            end
            rsp.interrupt_trap = hit;
        end

        if (!hit) begin
            rsp = '0;
            rsp.next_pc = r.following_pc;
            rsp.next_priv = r.cur_priv;
            rsp.status_out = st;
            return rsp;
        end

        rsp.trap_taken = 1'b1;
        rsp.saved_pc = rsp.interrupt_trap ? r.following_pc : r.cur_pc;
        rsp.trap_value = r.fault_value;

        // Handler address; reserved modes behave as direct.
        tvec = rsp.to_supervisor ? c.stvec : c.mtvec;
        rsp.next_pc = {tvec[31:2], 2'b00};
        if (tvec[1:0] == rtti_pkg::TVEC_VECTORED && rsp.interrupt_trap) begin
            rsp.next_pc = rsp.next_pc + {26'd0, rsp.cause_code, 2'b00};
        end

        // Stack the interrupt enable and record the previous privilege.
        rsp.status_out = st;
        if (rsp.to_supervisor) begin
            rsp.status_out[rtti_pkg::ST_SPIE] = st[rtti_pkg::ST_SIE];
            rsp.status_out[rtti_pkg::ST_SIE] = 1'b0;
            rsp.status_out[rtti_pkg::ST_SPP] = r.cur_priv[0];
            rsp.next_priv = rtti_pkg::PRIV_S;
        end else begin
            rsp.status_out[rtti_pkg::ST_MPIE] = st[rtti_pkg::ST_MIE];
            rsp.status_out[rtti_pkg::ST_MIE] = 1'b0;
            rsp.status_out[rtti_pkg::ST_MPP_HI:rtti_pkg::ST_MPP_LO] = r.cur_priv;
            rsp.next_priv = rtti_pkg::PRIV_M;
        end
        return rsp;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, actual %h", name, want, got);
            fault_count++;
        end
    endfunction

    // Receiver stalls at random.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge aclk) begin : result_check
        rtti_pkg::rsp_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (trap_queue.size() == 0) begin
                $error("result with no request outstanding");
                fault_count++;
            end else begin
                want = trap_queue.pop_front();
                check_field("trap_taken", 32'(want.trap_taken), 32'(m_trap_taken));
                check_field("to_supervisor", 32'(want.to_supervisor), 32'(m_to_supervisor));
                check_field("interrupt_trap", 32'(want.interrupt_trap),
                            32'(m_interrupt_trap));
                check_field("cause_code", 32'(want.cause_code), 32'(m_cause_code));
                check_field("saved_pc", want.saved_pc, m_saved_pc);
                check_field("trap_value", want.trap_value, m_trap_value);
                check_field("next_pc", want.next_pc, m_next_pc);
                check_field("next_priv", 32'(want.next_priv), 32'(m_next_priv));
                check_field("status_out", want.status_out, m_status_out);
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one request, with a random idle gap first; returns at a falling edge.
    task automatic send_request(input rtti_pkg::req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        req_drive <= r;
        do @(posedge aclk); while (!s_ready);
        trap_queue.push_back(predict_trap(r, shadow_cfg));
        @(negedge aclk);
    endtask

    // Hold the sender until every prediction has been matched, then let the pipe settle.
    task automatic drain_requests();
        s_valid <= 1'b0;
        while (trap_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_register(input logic [rtti_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            rtti_pkg::CFG_MTVEC:  shadow_cfg.mtvec = data;
            rtti_pkg::CFG_STVEC:  shadow_cfg.stvec = data;
            rtti_pkg::CFG_EDELEG: shadow_cfg.edeleg = data[15:0];
            rtti_pkg::CFG_IDELEG: shadow_cfg.ideleg = data[11:0];
            rtti_pkg::CFG_IE:     shadow_cfg.ie = data[11:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_config(input rtti_pkg::cfg_t c);
        write_register(rtti_pkg::CFG_MTVEC, c.mtvec);
        write_register(rtti_pkg::CFG_STVEC, c.stvec);
        write_register(rtti_pkg::CFG_EDELEG, {16'd0, c.edeleg});
        write_register(rtti_pkg::CFG_IDELEG, {20'd0, c.ideleg});
        write_register(rtti_pkg::CFG_IE, {20'd0, c.ie});
    endtask

    // Directed request; pc values and fault value are random.
    function automatic rtti_pkg::req_t make_request(logic [1:0] priv, logic [31:0] status,
                                                    logic exc, logic [3:0] code,
                                                    logic [11:0] pending,
                                                    logic sei, logic sti);
        rtti_pkg::req_t r;
        r.cur_pc = $urandom;
        r.following_pc = $urandom;
        r.cur_priv = priv;
        r.status_in = status;
        r.exc_valid = exc;
        r.exc_code = code;
        r.fault_value = $urandom;
        r.pending_lines = pending;
        r.ext_super_external = sei;
        r.ext_super_timer = sti;
        return r;
    endfunction

    // Random request, biased toward one or two of the real interrupt lines.
    function automatic rtti_pkg::req_t random_request();
        rtti_pkg::req_t r;
        r.cur_pc = $urandom;
        r.following_pc = $urandom;
        r.cur_priv = 2'($urandom_range(0, 3));
        r.status_in = $urandom;
        r.exc_valid = ($urandom_range(0, 99) < 30);
        r.exc_code = 4'($urandom_range(0, 15));
        r.fault_value = $urandom;
        r.pending_lines = '0;
        case ($urandom_range(0, 3))
            0: r.pending_lines = 12'($urandom);
            1: r.pending_lines[IRQ_ORDER[$urandom_range(0, 5)]] = 1'b1;
            2: begin
                r.pending_lines[IRQ_ORDER[$urandom_range(0, 5)]] = 1'b1;
                r.pending_lines[IRQ_ORDER[$urandom_range(0, 5)]] = 1'b1;
            end
            default: ;
        endcase
        r.ext_super_external = 1'($urandom_range(0, 1));
        r.ext_super_timer = 1'($urandom_range(0, 1));
        return r;
    endfunction

    // Register setting for one stretch of random traffic: all ones, all zeros or random.
    function automatic rtti_pkg::cfg_t random_config(int kind);
        rtti_pkg::cfg_t c;
        case (kind)
            0: c = '1;
            2: c = '0;
            default: begin
                c.mtvec = $urandom;
                c.stvec = $urandom;
                c.mtvec[1:0] = $urandom_range(0, 1) ? rtti_pkg::TVEC_VECTORED
                                                    : 2'($urandom_range(0, 3));
                c.stvec[1:0] = $urandom_range(0, 1) ? rtti_pkg::TVEC_VECTORED
                                                    : 2'($urandom_range(0, 3));
                c.edeleg = 16'($urandom);
                c.ideleg = 12'($urandom);
                c.ie = 12'($urandom | $urandom);
            end
        endcase
        return c;
    endfunction

    // Registers at their reset value: exceptions go to address zero, no interrupts.
    task automatic test_reset_values();
        send_request(make_request(rtti_pkg::PRIV_U, 32'h0, 1'b1, 4'd2, 12'h000, 1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_U, 32'hFFFF_FFFF, 1'b0, 4'd0, 12'hFFF,
                                  1'b1, 1'b1));
        drain_requests();
    endtask

    // Each interrupt alone, then the eligibility rules per privilege.
    task automatic test_interrupt_priority();
        rtti_pkg::cfg_t c;
        int i;
        c.mtvec = 32'h8000_0001;
        c.stvec = 32'h4000_0101;
        c.edeleg = 16'hFFFF;
        c.ideleg = 12'h222;
        c.ie = 12'hFFF;
        load_config(c);
        for (i = 0; i < 6; i++) begin
            send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b0, 4'd0,
                                      12'h1 << IRQ_ORDER[i], 1'b0, 1'b0));
        end
        send_request(make_request(rtti_pkg::PRIV_M, 32'h1 << rtti_pkg::ST_MIE, 1'b0, 4'd0,
                                  12'hFFF, 1'b1, 1'b1));
        send_request(make_request(rtti_pkg::PRIV_M, ~(32'h1 << rtti_pkg::ST_MIE), 1'b0, 4'd0,
                                  12'hFFF, 1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_S, ~(32'h1 << rtti_pkg::ST_SIE), 1'b0, 4'd0,
                                  12'h1 << rtti_pkg::IRQ_SEI, 1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_S, 32'h1 << rtti_pkg::ST_SIE, 1'b0, 4'd0,
                                  (12'h1 << rtti_pkg::IRQ_SEI) | (12'h1 << rtti_pkg::IRQ_SSI),
                                  1'b0, 1'b0));
        // Reserved privilege: S interrupts never eligible, M interrupts always.
        send_request(make_request(2'd2, 32'hFFFF_FFFF, 1'b0, 4'd0,
                                  12'h1 << rtti_pkg::IRQ_SEI, 1'b0, 1'b0));
        send_request(make_request(2'd2, 32'h0, 1'b0, 4'd0, 12'h1 << rtti_pkg::IRQ_MTI,
                                  1'b0, 1'b0));
        // External supervisor lines with no software pending bits.
        send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b0, 4'd0, 12'h000,
                                  1'b1, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b0, 4'd0, 12'h000,
                                  1'b0, 1'b1));
        drain_requests();
    endtask

    // Exception delegation by privilege, and an exception beating pending interrupts.
    task automatic test_exceptions();
        rtti_pkg::req_t r;
        send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b1, 4'd15, 12'h000,
                                  1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_M, $urandom, 1'b1, 4'd8, 12'h000,
                                  1'b0, 1'b0));
        send_request(make_request(2'd2, $urandom, 1'b1, 4'd0, 12'h000, 1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_S, 32'hFFFF_FFFF, 1'b1, 4'd3, 12'hFFF,
                                  1'b1, 1'b1));
        // Every field at its top value.
        r = make_request(rtti_pkg::PRIV_M, 32'hFFFF_FFFF, 1'b1, 4'd15, 12'hFFF, 1'b1, 1'b1);
        r.cur_pc = 32'hFFFF_FFFF;
        r.following_pc = 32'hFFFF_FFFF;
        r.fault_value = 32'hFFFF_FFFF;
        send_request(r);
        drain_requests();
        write_register(rtti_pkg::CFG_EDELEG, 32'h0);
        send_request(make_request(rtti_pkg::PRIV_S, $urandom, 1'b1, 4'd15, 12'h000,
                                  1'b0, 1'b0));
        drain_requests();
    endtask

    // Reserved vector modes act as direct; a vectored handler address wraps at the top.
    task automatic test_vector_modes();
        write_register(rtti_pkg::CFG_MTVEC, 32'hFFFF_FFFE);
        write_register(rtti_pkg::CFG_STVEC, 32'h0000_0003);
        send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b0, 4'd0,
                                  12'h1 << rtti_pkg::IRQ_MEI, 1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b0, 4'd0,
                                  12'h1 << rtti_pkg::IRQ_SEI, 1'b0, 1'b0));
        drain_requests();
        write_register(rtti_pkg::CFG_MTVEC, 32'hFFFF_FFFD);
        send_request(make_request(rtti_pkg::PRIV_U, $urandom, 1'b0, 4'd0,
                                  12'h1 << rtti_pkg::IRQ_MEI, 1'b0, 1'b0));
        send_request(make_request(rtti_pkg::PRIV_M, $urandom, 1'b1, 4'd11, 12'hFFF,
                                  1'b0, 1'b0));
        drain_requests();
    endtask

    // Random requests under several register settings at one idling mix.
    task automatic test_random_traffic(input int send_pct, input int recv_pct);
        int k;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (k = 0; k < 4; k++) begin
            load_config(random_config(k));
            repeat (ITEMS_PER_SETTING) send_request(random_request());
            drain_requests();
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_values();
        test_interrupt_priority();
        test_exceptions();
        test_vector_modes();
        test_random_traffic(10, 60);
        test_random_traffic(60, 10);
        test_random_traffic(0, 0);

        if (fault_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
